// ===== hdl/rdum_pkg.sv =====
package rdum_pkg;

   // coordinate and register widths
   localparam int COORD_BITS = 12;
   localparam int NUM_TERMS  = 5;
   localparam int NUM_K      = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int COEFF_BITS = 16;
   localparam int SCALE_BITS = 16;

   // radius path
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int R2_BITS   = 2 * COORD_BITS + 1;
   localparam int T1_BITS   = R2_BITS + SCALE_BITS;
   localparam int T2_BITS   = T1_BITS + SCALE_BITS;
   localparam int U_BITS    = 16;
   localparam int U_SHIFT   = 18;

   // Horner accumulator, Q20.12
   localparam int ACC_BITS  = 32;
   localparam int FRAC_BITS = 14;
   localparam int PROD_BITS = ACC_BITS + U_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS - FRAC_BITS + 1;
   localparam int ONE_Q12   = 4096;
   localparam int Q12_BITS  = 12;

   // divider
   localparam int NUM_BITS   = COORD_BITS + Q12_BITS;
   localparam int QBITS      = ((NUM_BITS + 1) / 2) * 2;
   localparam int DIV_STAGES = QBITS / 2;
   localparam int REM_BITS   = ACC_BITS;
   localparam int POS_BITS   = QBITS + 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_RADIUS   = 3'd2,
      REG_K1       = 3'd3,
      REG_K2       = 3'd4,
      REG_K3       = 3'd5,
      REG_K4       = 3'd6,
      REG_K5       = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
      logic [COORD_BITS-1:0]       px;
      logic [COORD_BITS-1:0]       py;
   } coord_type;

endpackage

// ===== hdl/radial_division_undistort_map.sv =====
// channel    | ports                                   | transfer when
// -----------+-----------------------------------------+---------------------------
// request    | start, busy, req_pixel_x, req_pixel_y    | start && !busy
// response   | rsp_valid, rsp_source_x/_y, rsp_clipped  | rsp_valid (one cycle)
// csr write  | csr_valid, csr_ready, csr_index, csr_wdata | csr_valid && csr_ready
//
// One pixel enters every cycle; busy is never raised. The pipeline holds four
// radius stages, one Horner stage per term, one divider setup stage, QBITS/2
// divider stages at two quotient bits each, and one output stage. The divider
// depth sets the latency.
// Reset (synchronous) clears every valid bit and loads the register defaults.
// The response side cannot stall, so the pipeline always advances.
module radial_division_undistort_map (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rdum_pkg::COORD_BITS-1:0]       req_pixel_x,
   input  logic [rdum_pkg::COORD_BITS-1:0]       req_pixel_y,
   output logic                                  rsp_valid,
   output logic [rdum_pkg::COORD_BITS-1:0]       rsp_source_x,
   output logic [rdum_pkg::COORD_BITS-1:0]       rsp_source_y,
   output logic                                  rsp_clipped,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rdum_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rdum_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rdum_pkg::*;

   localparam int LATENCY = 4 + NUM_TERMS + 1 + DIV_STAGES + 1;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // configuration registers
   logic [COORD_BITS-1:0]        center_x_ff;
   logic [COORD_BITS-1:0]        center_y_ff;
   logic [SCALE_BITS-1:0]        radius_scale_ff;
   logic signed [COEFF_BITS-1:0] k_ff [NUM_K];

   // accept every write and every pixel immediately
   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         radius_scale_ff <= '1;
         k_ff[0]         <= -16'sd4096;
         k_ff[1]         <= 16'sd41;
         k_ff[2]         <= 16'sd164;
         k_ff[3]         <= 16'sd8;
         k_ff[4]         <= 16'sd1229;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            REG_CENTER_X: center_x_ff     <= csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Y: center_y_ff     <= csr_wdata[COORD_BITS-1:0];
            REG_RADIUS:   radius_scale_ff <= csr_wdata[SCALE_BITS-1:0];
            REG_K1:       k_ff[0]         <= signed'(csr_wdata[COEFF_BITS-1:0]);
            REG_K2:       k_ff[1]         <= signed'(csr_wdata[COEFF_BITS-1:0]);
            REG_K3:       k_ff[2]         <= signed'(csr_wdata[COEFF_BITS-1:0]);
            REG_K4:       k_ff[3]         <= signed'(csr_wdata[COEFF_BITS-1:0]);
            REG_K5:       k_ff[4]         <= signed'(csr_wdata[COEFF_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: offsets from the centre
   // ---------------------------------------------------------------
   logic      s1_valid_ff;
   coord_type s1_data_ff;
   coord_type s1_data_in;

   always_comb begin
      s1_data_in.px = req_pixel_x;
      s1_data_in.py = req_pixel_y;
      s1_data_in.dx = signed'({1'b0, req_pixel_x}) - signed'({1'b0, center_x_ff});
      s1_data_in.dy = signed'({1'b0, req_pixel_y}) - signed'({1'b0, center_y_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
      s1_data_ff <= s1_data_in;
   end

   // ---------------------------------------------------------------
   // Stage 2: squared pixel radius
   // ---------------------------------------------------------------
   logic                      s2_valid_ff;
   coord_type                 s2_data_ff;
   logic [R2_BITS-1:0]        s2_r2_ff;
   logic signed [SQ_BITS-1:0] sqx;
   logic signed [SQ_BITS-1:0] sqy;

   assign sqx = s1_data_ff.dx * s1_data_ff.dx;
   assign sqy = s1_data_ff.dy * s1_data_ff.dy;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_data_ff <= s1_data_ff;
      s2_r2_ff   <= {1'b0, sqx[R2_BITS-2:0]} + {1'b0, sqy[R2_BITS-2:0]};
   end

   // ---------------------------------------------------------------
   // Stages 3 and 4: scale twice, then floor and saturate to Q2.14
   // ---------------------------------------------------------------
   logic               s3_valid_ff;
   coord_type          s3_data_ff;
   logic [T1_BITS-1:0] s3_t1_ff;
   logic [T2_BITS-1:0] t2;
   logic [U_BITS-1:0]  u_in;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_data_ff <= s2_data_ff;
      s3_t1_ff   <= T1_BITS'(s2_r2_ff) * T1_BITS'(radius_scale_ff);
   end

   assign t2   = T2_BITS'(s3_t1_ff) * T2_BITS'(radius_scale_ff);
   assign u_in = (|t2[T2_BITS-1:U_SHIFT+U_BITS]) ? '1 : t2[U_SHIFT+U_BITS-1:U_SHIFT];

   // Horner pipeline: index 0 holds u and the top coefficient
   logic                       h_valid_ff [NUM_TERMS+1];
   coord_type                  h_data_ff  [NUM_TERMS+1];
   logic [U_BITS-1:0]          h_u_ff     [NUM_TERMS+1];
   logic signed [ACC_BITS-1:0] h_acc_ff   [NUM_TERMS+1];
   logic signed [ACC_BITS-1:0] top_coeff;

   generate
      if (NUM_TERMS <= NUM_K) begin : g_top_k
         assign top_coeff = ACC_BITS'(k_ff[NUM_TERMS-1]);
      end else begin : g_top_zero
         assign top_coeff = '0;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff[0] <= 1'b0;
      else       h_valid_ff[0] <= s3_valid_ff;
      h_data_ff[0] <= s3_data_ff;
      h_u_ff[0]    <= u_in;
      h_acc_ff[0]  <= top_coeff;
   end

   // ---------------------------------------------------------------
   // Horner steps: acc = c + floor(acc * u / 2^14), saturating
   // ---------------------------------------------------------------
   generate
      for (genvar h = 0; h < NUM_TERMS; h++) begin : g_horner
         localparam int CI = NUM_TERMS - 1 - h;
         logic signed [ACC_BITS-1:0]  add_c;
         logic signed [PROD_BITS-1:0] prod;
         logic signed [SUM_BITS-1:0]  sum;
         logic signed [ACC_BITS-1:0]  acc_in;

         if (CI == 0) begin : g_one
            assign add_c = ACC_BITS'(ONE_Q12);
         end else if (CI <= NUM_K) begin : g_k
            assign add_c = ACC_BITS'(k_ff[CI-1]);
         end else begin : g_zero
            assign add_c = '0;
         end

         assign prod = h_acc_ff[h] * signed'({1'b0, h_u_ff[h]});
         // the part-select drops the low bits, flooring toward minus infinity
         assign sum  = SUM_BITS'(signed'(prod[PROD_BITS-1:FRAC_BITS])) + SUM_BITS'(add_c);

         always_comb begin
            if (sum > SUM_BITS'(ACC_MAX))      acc_in = ACC_MAX;
            else if (sum < SUM_BITS'(ACC_MIN)) acc_in = ACC_MIN;
            else                               acc_in = sum[ACC_BITS-1:0];
         end

         always_ff @(posedge clock) begin
            if (reset) h_valid_ff[h+1] <= 1'b0;
            else       h_valid_ff[h+1] <= h_valid_ff[h];
            h_data_ff[h+1] <= h_data_ff[h];
            h_u_ff[h+1]    <= h_u_ff[h];
            h_acc_ff[h+1]  <= acc_in;
         end
      end
   endgenerate

   // ---------------------------------------------------------------
   // Divider setup: magnitudes times 4096, divisor forced to one when
   // the denominator is not positive (its quotient is then dropped)
   // ---------------------------------------------------------------
   logic                   d_valid_ff [DIV_STAGES+1];
   coord_type              d_data_ff  [DIV_STAGES+1];
   logic                   d_pos_ff   [DIV_STAGES+1];
   logic [REM_BITS-1:0]    d_div_ff   [DIV_STAGES+1];
   logic [REM_BITS-1:0]    d_remx_ff  [DIV_STAGES+1];
   logic [REM_BITS-1:0]    d_remy_ff  [DIV_STAGES+1];
   logic [QBITS-1:0]       d_numx_ff  [DIV_STAGES+1];
   logic [QBITS-1:0]       d_numy_ff  [DIV_STAGES+1];
   logic [QBITS-1:0]       d_quox_ff  [DIV_STAGES+1];
   logic [QBITS-1:0]       d_quoy_ff  [DIV_STAGES+1];

   logic signed [ACC_BITS-1:0] den;
   logic                       den_pos;
   logic [DIFF_BITS-1:0]       magx;
   logic [DIFF_BITS-1:0]       magy;

   assign den     = h_acc_ff[NUM_TERMS];
   assign den_pos = den > 0;
   assign magx    = h_data_ff[NUM_TERMS].dx[DIFF_BITS-1] ?
                    DIFF_BITS'(-h_data_ff[NUM_TERMS].dx) : DIFF_BITS'(h_data_ff[NUM_TERMS].dx);
   assign magy    = h_data_ff[NUM_TERMS].dy[DIFF_BITS-1] ?
                    DIFF_BITS'(-h_data_ff[NUM_TERMS].dy) : DIFF_BITS'(h_data_ff[NUM_TERMS].dy);

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff[0] <= 1'b0;
      else       d_valid_ff[0] <= h_valid_ff[NUM_TERMS];
      d_data_ff[0] <= h_data_ff[NUM_TERMS];
      d_pos_ff[0]  <= den_pos;
      d_div_ff[0]  <= den_pos ? REM_BITS'(den) : REM_BITS'(1);
      d_remx_ff[0] <= '0;
      d_remy_ff[0] <= '0;
      d_numx_ff[0] <= QBITS'({magx[COORD_BITS-1:0], {Q12_BITS{1'b0}}});
      d_numy_ff[0] <= QBITS'({magy[COORD_BITS-1:0], {Q12_BITS{1'b0}}});
      d_quox_ff[0] <= '0;
      d_quoy_ff[0] <= '0;
   end

   // ---------------------------------------------------------------
   // Restoring divider: two quotient bits per stage for each axis
   // ---------------------------------------------------------------
   generate
      for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
         logic [REM_BITS-1:0] remx_in, remy_in;
         logic [QBITS-1:0]    numx_in, numy_in, quox_in, quoy_in;

         always_comb begin
            logic [REM_BITS:0] candx;
            logic [REM_BITS:0] candy;
            remx_in = d_remx_ff[j];
            remy_in = d_remy_ff[j];
            numx_in = d_numx_ff[j];
            numy_in = d_numy_ff[j];
            quox_in = d_quox_ff[j];
            quoy_in = d_quoy_ff[j];
            for (int b = 0; b < 2; b++) begin
               candx   = {remx_in, numx_in[QBITS-1]};
               candy   = {remy_in, numy_in[QBITS-1]};
               numx_in = {numx_in[QBITS-2:0], 1'b0};
               numy_in = {numy_in[QBITS-2:0], 1'b0};
               if (candx >= {1'b0, d_div_ff[j]}) begin
                  remx_in = REM_BITS'(candx - {1'b0, d_div_ff[j]});
                  quox_in = {quox_in[QBITS-2:0], 1'b1};
               end else begin
                  remx_in = candx[REM_BITS-1:0];
                  quox_in = {quox_in[QBITS-2:0], 1'b0};
               end
               if (candy >= {1'b0, d_div_ff[j]}) begin
                  remy_in = REM_BITS'(candy - {1'b0, d_div_ff[j]});
                  quoy_in = {quoy_in[QBITS-2:0], 1'b1};
               end else begin
                  remy_in = candy[REM_BITS-1:0];
                  quoy_in = {quoy_in[QBITS-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) d_valid_ff[j+1] <= 1'b0;
            else       d_valid_ff[j+1] <= d_valid_ff[j];
            d_data_ff[j+1] <= d_data_ff[j];
            d_pos_ff[j+1]  <= d_pos_ff[j];
            d_div_ff[j+1]  <= d_div_ff[j];
            d_remx_ff[j+1] <= remx_in;
            d_remy_ff[j+1] <= remy_in;
            d_numx_ff[j+1] <= numx_in;
            d_numy_ff[j+1] <= numy_in;
            d_quox_ff[j+1] <= quox_in;
            d_quoy_ff[j+1] <= quoy_in;
         end
      end
   endgenerate

   // ---------------------------------------------------------------
   // Output stage: add the centre back, saturate, flag clipping
   // ---------------------------------------------------------------
   localparam logic signed [POS_BITS-1:0] MAX_COORD =
      {{(POS_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

   coord_type                  fin;
   logic signed [POS_BITS-1:0] posx, posy, qx, qy;
   logic [COORD_BITS-1:0]      srcx_in, srcy_in;
   logic                       clip_in;
   logic                       rsp_valid_ff;
   logic [COORD_BITS-1:0]      rsp_source_x_ff, rsp_source_y_ff;
   logic                       rsp_clipped_ff;

   assign fin  = d_data_ff[DIV_STAGES];
   assign qx   = signed'({2'b00, d_quox_ff[DIV_STAGES]});
   assign qy   = signed'({2'b00, d_quoy_ff[DIV_STAGES]});
   assign posx = signed'({{(POS_BITS-COORD_BITS){1'b0}}, center_x_ff}) +
                 (fin.dx[DIFF_BITS-1] ? -qx : qx);
   assign posy = signed'({{(POS_BITS-COORD_BITS){1'b0}}, center_y_ff}) +
                 (fin.dy[DIFF_BITS-1] ? -qy : qy);

   always_comb begin
      clip_in = 1'b0;
      if (!d_pos_ff[DIV_STAGES]) begin
         // denominator not positive: pass the pixel through and flag it
         srcx_in = fin.px;
         srcy_in = fin.py;
         clip_in = 1'b1;
      end else begin
         if (posx < 0) begin
            srcx_in = '0;
            clip_in = 1'b1;
         end else if (posx > MAX_COORD) begin
            srcx_in = '1;
            clip_in = 1'b1;
         end else begin
            srcx_in = posx[COORD_BITS-1:0];
         end
         if (posy < 0) begin
            srcy_in = '0;
            clip_in = 1'b1;
         end else if (posy > MAX_COORD) begin
            srcy_in = '1;
            clip_in = 1'b1;
         end else begin
            srcy_in = posy[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= d_valid_ff[DIV_STAGES];
      rsp_source_x_ff <= srcx_in;
      rsp_source_y_ff <= srcy_in;
      rsp_clipped_ff  <= clip_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_source_x = rsp_source_x_ff;
   assign rsp_source_y = rsp_source_y_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a request LATENCY cycles earlier");

   a_nonpos_clip : assert property (@(posedge clock) disable iff (reset)
      d_valid_ff[DIV_STAGES] && !d_pos_ff[DIV_STAGES] |=> rsp_valid && rsp_clipped)
      else $error("non-positive denominator not flagged as clipped");

   a_den_flag : assert property (@(posedge clock) disable iff (reset)
      h_valid_ff[NUM_TERMS] |=> d_valid_ff[0] && (d_pos_ff[0] == ($past(den) > 0)))
      else $error("denominator sign lost entering the divider");

endmodule

// ===== tb/radial_division_undistort_map_checker.sv =====
`timescale 1ns / 1ps

module radial_division_undistort_map_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [rdum_pkg::COORD_BITS-1:0]    req_pixel_x,
   input  logic [rdum_pkg::COORD_BITS-1:0]    req_pixel_y,
   input  logic                               rsp_valid,
   input  logic [rdum_pkg::COORD_BITS-1:0]    rsp_source_x,
   input  logic [rdum_pkg::COORD_BITS-1:0]    rsp_source_y,
   input  logic                               rsp_clipped,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [rdum_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rdum_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 pending_maps,
   output int                                 maps_checked,
   output int                                 maps_clipped
);
   import rdum_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic                  clip;
   } mapped_pixel_type;

   logic [COORD_BITS-1:0] cen_x, cen_y;
   logic [SCALE_BITS-1:0] rscale;
   logic [COEFF_BITS-1:0] kcoef [1:NUM_K];
   mapped_pixel_type      mapped_q [$];

   function automatic longint sat_q12(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint coef_at(int i);
      if (i >= 1 && i <= NUM_K) return longint'($signed(kcoef[i]));
      return 0;
   endfunction

   function automatic logic [COORD_BITS-1:0] scale_coord(longint c, longint d, longint den,
                                                         inout logic clip);
      longint mag, q, s, maxc;
      maxc = (64'sd1 << COORD_BITS) - 1;
      mag  = (d < 0 ? -d : d) * 4096;
      q    = mag / den;
      s    = c + (d < 0 ? -q : q);
      if (s < 0) begin
         clip = 1'b1;
         return '0;
      end
      if (s > maxc) begin
         clip = 1'b1;
         return '1;
      end
      return s[COORD_BITS-1:0];
   endfunction

   function automatic mapped_pixel_type undistort(logic [COORD_BITS-1:0] px,
                                                  logic [COORD_BITS-1:0] py);
      mapped_pixel_type m;
      longint dx, dy, acc, den, u;
      longint unsigned r2, s2, prod;
      logic clip;
      dx = longint'(px) - longint'(cen_x);
      dy = longint'(py) - longint'(cen_y);
      r2 = dx * dx + dy * dy;
      s2 = longint'(rscale) * longint'(rscale);
      // r2 < 2^25 and s2 < 2^32, so the product fits in 64 bits
      prod = (r2 * s2) >> U_SHIFT;
      u = (prod > 65535) ? 65535 : prod;
      acc = coef_at(NUM_TERMS);
      for (int i = NUM_TERMS - 1; i >= 1; i--)
         acc = sat_q12(coef_at(i) + ((acc * u) >>> FRAC_BITS));
      den = sat_q12(ONE_Q12 + ((acc * u) >>> FRAC_BITS));
      clip = 1'b0;
      if (den <= 0) begin
         m.sx = px;
         m.sy = py;
         clip = 1'b1;
      end else begin
         m.sx = scale_coord(longint'(cen_x), dx, den, clip);
         m.sy = scale_coord(longint'(cen_y), dy, den, clip);
      end
      m.clip = clip;
      return m;
   endfunction

   assign pending_maps = mapped_q.size();

   always @(posedge clock) begin
      mapped_pixel_type want;
      if (reset) begin
         cen_x  <= '0;
         cen_y  <= '0;
         rscale <= 16'hFFFF;
         kcoef[1] <= -16'sd4096;
         kcoef[2] <= 16'd41;
         kcoef[3] <= 16'd164;
         kcoef[4] <= 16'd8;
         kcoef[5] <= 16'd1229;
         mapped_q.delete();
         fail_count   <= 0;
         maps_checked <= 0;
         maps_clipped <= 0;
      end else begin
         if (rsp_valid) begin
            if (mapped_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result %0d,%0d clip %0b", $time,
                           rsp_source_x, rsp_source_y, rsp_clipped);
               fail_count <= fail_count + 1;
            end else begin
               want = mapped_q.pop_front();
               maps_checked <= maps_checked + 1;
               if (rsp_clipped) maps_clipped <= maps_clipped + 1;
               if (want.sx !== rsp_source_x || want.sy !== rsp_source_y
                   || want.clip !== rsp_clipped) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp %0d,%0d clip %0b got %0d,%0d clip %0b",
                              $time, want.sx, want.sy, want.clip,
                              rsp_source_x, rsp_source_y, rsp_clipped);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            mapped_q.insert(mapped_q.size(), undistort(req_pixel_x, req_pixel_y));
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               REG_CENTER_X: cen_x  <= csr_wdata[COORD_BITS-1:0];
               REG_CENTER_Y: cen_y  <= csr_wdata[COORD_BITS-1:0];
               REG_RADIUS:   rscale <= csr_wdata;
               REG_K1:       kcoef[1] <= csr_wdata;
               REG_K2:       kcoef[2] <= csr_wdata;
               REG_K3:       kcoef[3] <= csr_wdata;
               REG_K4:       kcoef[4] <= csr_wdata;
               REG_K5:       kcoef[5] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/tb_radial_division_undistort_map.sv =====
`timescale 1ns / 1ps

module tb_radial_division_undistort_map;
   import rdum_pkg::*;

   // pipeline depth of the block plus margin for the drain at the end
   localparam int DRAIN_CYCLES = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [COORD_BITS-1:0]    req_pixel_x = '0;
   logic [COORD_BITS-1:0]    req_pixel_y = '0;
   logic                     rsp_valid;
   logic [COORD_BITS-1:0]    rsp_source_x, rsp_source_y;
   logic                     rsp_clipped;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int                       fail_count, pending_maps, maps_checked, maps_clipped;
   int                       pixels_sent = 0;

   always #2 clock = ~clock;

   radial_division_undistort_map u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_source_x(rsp_source_x),
      .rsp_source_y(rsp_source_y), .rsp_clipped(rsp_clipped),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   radial_division_undistort_map_checker u_checker (.*);

   // Write one register and wait for the transfer; the caller drops valid
   // after the last write of a burst.
   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Offer one pixel, then hold it until the block takes it. Idle first with
   // the given percentage so gaps land on every pipeline phase.
   task automatic send_pixel(int px, int py, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_pixel_x <= COORD_BITS'(px);
      req_pixel_y <= COORD_BITS'(py);
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
   endtask

   // Drain all outstanding maps and let the pipeline empty before a csr write.
   task automatic drain;
      start <= 1'b0;
      while (pending_maps != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(logic [11:0] cx, logic [11:0] cy, logic [15:0] rs,
                            logic [15:0] k1, logic [15:0] k2, logic [15:0] k3,
                            logic [15:0] k4, logic [15:0] k5);
      write_csr(REG_CENTER_X, {4'h0, cx});
      write_csr(REG_CENTER_Y, {4'h0, cy});
      write_csr(REG_RADIUS, rs);
      write_csr(REG_K1, k1);
      write_csr(REG_K2, k2);
      write_csr(REG_K3, k3);
      write_csr(REG_K4, k4);
      write_csr(REG_K5, k5);
      csr_valid <= 1'b0;
   endtask

   // Mostly pixels near the centre, where the denominator stays sane,
   // with full-range pixels mixed in.
   task automatic random_pixels(int count, int idle_pct);
      int px, py;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            px = int'($urandom_range(4095));
            py = int'($urandom_range(4095));
         end else begin
            px = int'(2048 + $urandom_range(1200) - 600);
            py = int'(2048 + $urandom_range(1200) - 600);
         end
         send_pixel(px, py, idle_pct);
      end
   endtask

   task automatic random_config;
      write_all(12'($urandom), 12'($urandom), 16'($urandom_range(400, 20)),
                16'($urandom_range(8192) - 4096), 16'($urandom_range(2048) - 1024),
                16'($urandom_range(1024) - 512), 16'($urandom_range(512) - 256),
                16'($urandom_range(512) - 256));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: huge radius scale, u saturates for most pixels
      send_pixel(0, 0, 0);
      send_pixel(4095, 4095, 0);
      send_pixel(1, 0, 0);
      send_pixel(0, 1, 0);
      drain();

      // extreme registers: centre at the top corner, zero scale, identity
      write_all(12'hFFF, 12'hFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                16'h8000);
      send_pixel(0, 0, 0);
      send_pixel(4095, 4095, 0);
      send_pixel(2048, 0, 0);
      drain();

      // strong negative k1: denominator goes non-positive off centre
      write_all(12'd2048, 12'd2048, 16'd1000, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0);
      send_pixel(2048, 2048, 0);
      send_pixel(0, 0, 0);
      send_pixel(4095, 0, 0);
      send_pixel(0, 4095, 0);
      send_pixel(2100, 2000, 0);
      drain();

      // shrinking denominator pushes results out of range; max scale, max k
      write_all(12'd2048, 12'd2048, 16'd200, 16'hF100, 16'h0, 16'h0, 16'h0, 16'h0);
      send_pixel(0, 0, 0);
      send_pixel(4095, 4095, 0);
      send_pixel(3000, 1000, 0);
      drain();
      write_all(12'd0, 12'd4095, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                16'h7FFF);
      send_pixel(0, 4095, 0);
      send_pixel(4095, 0, 0);
      send_pixel(2730, 1365, 0);
      drain();

      // random phases: sender idle 37%, then 78%, then back to back
      random_config();
      random_pixels(420, 37);
      drain();
      random_config();
      random_pixels(420, 78);
      drain();
      write_csr(REG_CENTER_X, 16'd2048);
      write_csr(REG_CENTER_Y, 16'd2048);
      csr_valid <= 1'b0;
      random_pixels(410, 0);
      drain();

      $display("Sent %0d pixels and mapped %0d over several register settings, %0d clipped.",
               pixels_sent, maps_checked, maps_clipped);
      if (fail_count == 0 && pending_maps == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rdum_pkg.sv
hdl/radial_division_undistort_map.sv
tb/radial_division_undistort_map_checker.sv
tb/tb_radial_division_undistort_map.sv
